### rtl/ptd_pkg.sv
// Shared constants, types and register indexes of the plane tap detector.
`timescale 1ns / 1ps

package ptd_pkg;

	localparam int HANDS = 2;
	localparam int TIPS = 5;
	localparam int ENTRIES = HANDS * TIPS;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int FINGER_W = 3;
	localparam int POS_W = 21;
	localparam int DIFF_W = POS_W + 1;
	localparam int COMP_W = 18;
	localparam int PROD_W = DIFF_W + COMP_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int FRAC_W = 16;
	localparam int RND_W = SUM_W - FRAC_W;
	localparam int DIST_W = 24;
	localparam int CMP_W = DIST_W + 1;
	localparam int COORD_W = 23;
	localparam int THR_W = 17;
	localparam int CONF_W = 16;

	localparam int ORIGIN_W = 3 * POS_W;
	localparam int VEC_W = 3 * COMP_W;
	localparam int CFG_W = ORIGIN_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NORMAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLAB_HALF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_LEVEL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CONFIDENCE = 3'd6;

	localparam logic [THR_W-1:0] SLAB_RESET = 17'd328;
	localparam logic [THR_W-1:0] LIFT_RESET = 17'd655;
	localparam logic [CONF_W-1:0] MIN_CONF_RESET = 16'd13107;

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [DIST_W-1:0] dist_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic action;
		logic hand_ok;
		logic finger_ok;
		logic conf_ok;
		logic hand;
		logic [FINGER_W-1:0] finger;
	} item_ctl_t;

endpackage

### rtl/plane_tap_detector_unit.sv
// Top level of the plane tap detector: tip distance pipeline and per-tip tap state.
`timescale 1ns / 1ps

// Usage
// Input items (fingertip samples or hand-absent events) enter on the in_valid / in_ready
// channel; tap results leave on the out_valid / out_ready channel, zero or one per item.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata while the
// block is idle; a write takes effect at the clock edge where cfg_we is high.
// The pipeline has three stages: difference to origin, the nine products, then the
// rounded dot products. The last stage reads the per-tip marks, decides on a tap and
// writes the distance back to the distance memory, whose read port sits one stage earlier;
// writes that overlap a pending read are forwarded. A result goes to the output register
// when its item retires from the last stage; one item is accepted every cycle unless stalled.
// Reset clears the valid and suppression marks of all tips and loads the register
// defaults; the distance memory is not cleared, since it is read only behind a valid mark.
// When the receiver stalls, a result waits in the output register while the pipeline
// keeps filling; in_ready drops once all three stages hold items, the last a tap that waits.
module plane_tap_detector_unit import ptd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic                 hand,
	input  logic [FINGER_W-1:0]  finger,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [CONF_W-1:0]    confidence,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 tap_hand,
	output logic [FINGER_W-1:0]  tap_finger,
	output logic signed [COORD_W-1:0] plane_u,
	output logic signed [COORD_W-1:0] plane_v,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	function automatic logic signed [RND_W-1:0] round_sum(input prod_t a, input prod_t b,
			input prod_t c);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + ROUND_HALF;
		return s[SUM_W-1:FRAC_W];
	endfunction

	function automatic logic signed [RND_W-1:0] sat_w(input logic signed [RND_W-1:0] x,
			input int w);
		logic signed [RND_W-1:0] hi;
		logic signed [RND_W-1:0] lo;
		hi = (RND_W'(1) << (w - 1)) - RND_W'(1);
		lo = ~hi;
		if (x > hi) begin
			return hi;
		end else if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	logic [ORIGIN_W-1:0] origin_q;
	logic [VEC_W-1:0] normal_q;
	logic [VEC_W-1:0] axis_a_q;
	logic [VEC_W-1:0] axis_b_q;
	logic [THR_W-1:0] slab_q;
	logic [THR_W-1:0] lift_q;
	logic [CONF_W-1:0] min_conf_q;

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] supp_q;
	logic [DIST_W-1:0] dist_mem [ENTRIES];
	logic [DIST_W-1:0] mem_rd_q;

	logic v_s1, v_s2, v_s3;
	item_ctl_t ctl_s1, ctl_s2, ctl_s3;
	idx_t idx_s1, idx_s2, idx_s3;
	diff_t diff_s1 [3];
	prod_t prod_n_s2 [3];
	prod_t prod_a_s2 [3];
	prod_t prod_b_s2 [3];
	logic byp_s2;
	dist_t byp_dist_s2;
	dist_t dist_s3;
	dist_t prev_s3;
	coord_t coord_u_s3;
	coord_t coord_v_s3;

	logic out_valid_q;
	logic out_hand_q;
	logic [FINGER_W-1:0] out_finger_q;
	coord_t out_u_q;
	coord_t out_v_q;

	logic signed [POS_W-1:0] org [3];
	logic signed [POS_W-1:0] pos [3];
	comp_t comp_n [3];
	comp_t comp_a [3];
	comp_t comp_b [3];
	diff_t diff_in [3];
	item_ctl_t ctl_in;
	idx_t idx_in;
	logic accept;
	logic en1, en2, retire3;
	logic sample3, tap3, mem_we, wr_hit1, wr_hit2;
	logic supp_e, valid_e;
	dist_t prev2;
	logic signed [RND_W-1:0] rnd_n, rnd_a, rnd_b, sat_n, sat_a, sat_b;
	logic signed [CMP_W-1:0] d_c, prev_c, slab_c, neg_slab_c, lift_c;

	always_comb begin
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
		for (int i = 0; i < 3; i++) begin
			org[i] = origin_q[i*POS_W +: POS_W];
			comp_n[i] = normal_q[i*COMP_W +: COMP_W];
			comp_a[i] = axis_a_q[i*COMP_W +: COMP_W];
			comp_b[i] = axis_b_q[i*COMP_W +: COMP_W];
			diff_in[i] = DIFF_W'(pos[i]) - DIFF_W'(org[i]);
		end
	end

	always_comb begin
		ctl_in.action = action;
		ctl_in.hand_ok = 32'(hand) < HANDS;
		ctl_in.finger_ok = 32'(finger) < TIPS;
		ctl_in.conf_ok = confidence >= min_conf_q;
		ctl_in.hand = hand;
		ctl_in.finger = finger;
		idx_in = IDX_W'(hand) * IDX_W'(TIPS) + IDX_W'(finger);
	end

	assign rnd_n = round_sum(prod_n_s2[0], prod_n_s2[1], prod_n_s2[2]);
	assign rnd_a = round_sum(prod_a_s2[0], prod_a_s2[1], prod_a_s2[2]);
	assign rnd_b = round_sum(prod_b_s2[0], prod_b_s2[1], prod_b_s2[2]);
	assign sat_n = sat_w(rnd_n, DIST_W);
	assign sat_a = sat_w(rnd_a, COORD_W);
	assign sat_b = sat_w(rnd_b, COORD_W);

	assign supp_e = supp_q[idx_s3];
	assign valid_e = valid_q[idx_s3];
	assign d_c = CMP_W'(dist_s3);
	assign prev_c = CMP_W'(prev_s3);
	assign slab_c = CMP_W'(slab_q);
	assign neg_slab_c = -slab_c;
	assign lift_c = CMP_W'(lift_q);

	assign sample3 = v_s3 && !ctl_s3.action && ctl_s3.hand_ok && ctl_s3.finger_ok;
	assign tap3 = sample3 && ctl_s3.conf_ok && !supp_e && valid_e && (d_c <= slab_c)
		&& (d_c >= neg_slab_c) && (d_c < prev_c) && (prev_c >= neg_slab_c);
	assign retire3 = v_s3 && (!tap3 || !out_valid_q || out_ready);
	assign en2 = !v_s3 || retire3;
	assign en1 = !v_s2 || en2;
	assign in_ready = !v_s1 || en1;
	assign accept = in_valid && in_ready;

	assign mem_we = retire3 && sample3 && ctl_s3.conf_ok;
	assign wr_hit1 = mem_we && (idx_s3 == idx_s1);
	assign wr_hit2 = mem_we && (idx_s3 == idx_s2);
	assign prev2 = byp_s2 ? byp_dist_s2 : mem_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			normal_q <= '0;
			axis_a_q <= '0;
			axis_b_q <= '0;
			slab_q <= SLAB_RESET;
			lift_q <= LIFT_RESET;
			min_conf_q <= MIN_CONF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PLANE_ORIGIN: origin_q <= cfg_wdata[ORIGIN_W-1:0];
				REG_PLANE_NORMAL: normal_q <= cfg_wdata[VEC_W-1:0];
				REG_AXIS_FIRST: axis_a_q <= cfg_wdata[VEC_W-1:0];
				REG_AXIS_SECOND: axis_b_q <= cfg_wdata[VEC_W-1:0];
				REG_SLAB_HALF: slab_q <= cfg_wdata[THR_W-1:0];
				REG_LIFT_LEVEL: lift_q <= cfg_wdata[THR_W-1:0];
				REG_MIN_CONFIDENCE: min_conf_q <= cfg_wdata[CONF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			byp_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (en1) begin
				v_s2 <= v_s1;
				byp_s2 <= wr_hit1;
			end else if (wr_hit2) begin
				byp_s2 <= 1'b1;
			end
			if (en2) begin
				v_s3 <= v_s2;
			end
			if (retire3 && tap3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			supp_q <= '0;
		end else if (retire3 && ctl_s3.hand_ok) begin
			if (ctl_s3.action) begin
				for (int t = 0; t < TIPS; t++) begin
					valid_q[IDX_W'(ctl_s3.hand) * IDX_W'(TIPS) + IDX_W'(t)] <= 1'b0;
					supp_q[IDX_W'(ctl_s3.hand) * IDX_W'(TIPS) + IDX_W'(t)] <= 1'b0;
				end
			end else if (ctl_s3.finger_ok) begin
				if (!ctl_s3.conf_ok) begin
					valid_q[idx_s3] <= 1'b0;
				end else begin
					valid_q[idx_s3] <= 1'b1;
					if (supp_e) begin
						if (d_c > lift_c) begin
							supp_q[idx_s3] <= 1'b0;
						end
					end else if (tap3) begin
						supp_q[idx_s3] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dist_mem[idx_s3] <= dist_s3;
		end
		if (en1) begin
			mem_rd_q <= dist_mem[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_in;
			idx_s1 <= idx_in;
			diff_s1 <= diff_in;
		end
		if (en1) begin
			ctl_s2 <= ctl_s1;
			idx_s2 <= idx_s1;
			for (int i = 0; i < 3; i++) begin
				prod_n_s2[i] <= PROD_W'(diff_s1[i]) * PROD_W'(comp_n[i]);
				prod_a_s2[i] <= PROD_W'(diff_s1[i]) * PROD_W'(comp_a[i]);
				prod_b_s2[i] <= PROD_W'(diff_s1[i]) * PROD_W'(comp_b[i]);
			end
		end
		if (en1 ? wr_hit1 : wr_hit2) begin
			byp_dist_s2 <= dist_s3;
		end
		if (en2) begin
			ctl_s3 <= ctl_s2;
			idx_s3 <= idx_s2;
			dist_s3 <= sat_n[DIST_W-1:0];
			coord_u_s3 <= sat_a[COORD_W-1:0];
			coord_v_s3 <= sat_b[COORD_W-1:0];
			prev_s3 <= wr_hit2 ? dist_s3 : prev2;
		end
		if (retire3 && tap3) begin
			out_hand_q <= ctl_s3.hand;
			out_finger_q <= ctl_s3.finger;
			out_u_q <= coord_u_s3;
			out_v_q <= coord_v_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign tap_hand = out_hand_q;
	assign tap_finger = out_finger_q;
	assign plane_u = out_u_q;
	assign plane_v = out_v_q;

endmodule

### rtl/ptd_checker.sv
// Port-level assertions for the plane tap detector and their binding to the top level.
`timescale 1ns / 1ps

module ptd_checker import ptd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 tap_hand,
	input logic [FINGER_W-1:0]  tap_finger,
	input logic signed [COORD_W-1:0] plane_u,
	input logic signed [COORD_W-1:0] plane_v
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tap_hand) && $stable(tap_finger)
			&& $stable(plane_u) && $stable(plane_v))
		else $error("A stalled tap item changed or vanished.");

	a_tap_finger: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(tap_finger) < TIPS)
		else $error("A tap item names a fingertip that does not exist.");

	a_tap_hand: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(tap_hand) < HANDS)
		else $error("A tap item names a hand that does not exist.");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input was refused while the output side was not stalled.");

endmodule

bind plane_tap_detector_unit ptd_checker u_ptd_checker (.*);
